[rtl/image_median_filter_top_defines.svh]
// Assertion macros used by the checker of the median filter.
// No dependencies.
`ifndef IMAGE_MEDIAN_FILTER_TOP_DEFINES_SVH
`define IMAGE_MEDIAN_FILTER_TOP_DEFINES_SVH

// antecedent implies consequent in the same cycle
`define MF_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("median filter check failed");

// antecedent implies consequent in the next cycle
`define MF_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("median filter check failed");

`endif

[rtl/imf_pkg.sv]
// Shared constants, types and helpers of the median filter.
// No dependencies.
`default_nettype none
package imf_pkg;
  localparam int MAX_RADIUS_DEF   = 2;
  localparam int MAX_WIDTH_DEF    = 1024;
  localparam int MAX_CHANNELS_DEF = 4;

  // register indexes of the configuration port
  localparam logic [1:0] REG_RADIUS   = 2'd0;
  localparam logic [1:0] REG_WIDTH    = 2'd1;
  localparam logic [1:0] REG_HEIGHT   = 2'd2;
  localparam logic [1:0] REG_CHANNELS = 2'd3;

  typedef struct packed {
    logic clear;
    logic insert;
  } sort_ctl_t;

  // address bits for a count of values, at least one
  function automatic int wbits(input int count);
    int b;
    b = $clog2(count);
    return (b < 1) ? 1 : b;
  endfunction
endpackage
`default_nettype wire

[rtl/imf_line_mem.sv]
// Line store: synchronous memory, one write and one registered read port.
// Depends on nothing.
`default_nettype none
module imf_line_mem #(
  parameter int AW = 15
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [7:0]    wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [7:0]    rdata
);
  logic [7:0] mem [0:(1<<AW)-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule
`default_nettype wire

[rtl/imf_sorter.sv]
// Insertion sorter: a row of cells kept in ascending order, one value a cycle.
// Depends on imf_pkg.
`default_nettype none
module imf_sorter #(
  parameter int MAX_RADIUS = imf_pkg::MAX_RADIUS_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire imf_pkg::sort_ctl_t ctl,
  input  wire logic [7:0]        value,
  input  wire logic [1:0]        radius,
  output logic      [7:0]        median
);
  localparam int SIDE = 2 * MAX_RADIUS + 1;
  localparam int N    = SIDE * SIDE;
  localparam int CNTW = $clog2(N + 1);

  logic [7:0]      sorted [0:N-1];
  logic [CNTW-1:0] cnt;
  logic [N-1:0]    gt;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      gt[i] = (i >= int'(cnt)) || (sorted[i] > value);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      cnt <= '0;
    end else if (ctl.insert) begin
      cnt <= cnt + CNTW'(1);
    end
  end

  // each cell takes the new value or its lower neighbour once the value ranks below it
  for (genvar g = 0; g < N; g++) begin : g_cell
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (ctl.insert && gt[0]) begin
          sorted[0] <= value;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (ctl.insert && gt[g]) begin
          sorted[g] <= gt[g-1] ? sorted[g-1] : value;
        end
      end
    end
  end

  always_comb begin
    median = sorted[0];
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      if (int'(radius) == k) begin
        median = sorted[((2*k+1)*(2*k+1))/2];
      end
    end
  end
endmodule
`default_nettype wire

[rtl/image_median_filter_top.sv]
// Median filter top: counters, line store sequencing and result register.
// A sample with no result leaves the filter idle; a config error goes to DONE;
// a median reads its window in READ, one window value a cycle via the single
// line store read port, then DRAIN, DONE. A stalled result holds back the next
// result-bearing request; samples enter only in IDLE. Reset (rst, synchronous):
// counters cleared, registers to r=1, 640x480, 3 channels; line store undefined.
`default_nettype none
module image_median_filter_top #(
  parameter int MAX_RADIUS   = imf_pkg::MAX_RADIUS_DEF,
  parameter int MAX_WIDTH    = imf_pkg::MAX_WIDTH_DEF,
  parameter int MAX_CHANNELS = imf_pkg::MAX_CHANNELS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // sample
  input  wire logic [0:0]  s_tuser,   // frame_start
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic      [7:0]  m_tdata,   // median_value
  output logic             m_tlast,   // row_end
  output logic      [1:0]  m_tuser,   // frame_end, config_error
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  localparam int WIN_SIDE = 2 * MAX_RADIUS + 1;
  localparam int SW  = imf_pkg::wbits(WIN_SIDE);
  localparam int CW  = imf_pkg::wbits(MAX_WIDTH);
  localparam int CHW = imf_pkg::wbits(MAX_CHANNELS);
  localparam int AW  = SW + CW + CHW;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_DONE  = 2'd3;

  logic [1:0]  radius;
  logic [10:0] width;
  logic [15:0] height;
  logic [2:0]  chans;

  logic [CW-1:0]  col, col_next;
  logic [15:0]    row, row_next;
  logic [CHW-1:0] ch, ch_next;
  logic [SW-1:0]  slot_mod [1:MAX_RADIUS];
  logic [SW-1:0]  slot_next [1:MAX_RADIUS];

  logic [1:0] state;
  logic       accept, bad, clr, has_win, rend, fend;
  logic [2:0] n, two_r;
  logic [CW-1:0]  pc;
  logic [15:0]    pr;
  logic [CHW-1:0] pch;
  logic [SW-1:0]  cur_slot, first_slot;

  logic [SW-1:0]  rd_slot, dr, dc;
  logic [CW-1:0]  col_base;
  logic [CHW-1:0] wch;
  logic           rd_pend, rd_last, rd_issue;
  logic [AW-1:0]  raddr;
  logic [7:0]     rdata, median;
  logic           res_err, res_rend, res_fend;
  imf_pkg::sort_ctl_t sctl;

  assign cfg_ready = 1'b1;
  assign s_tready  = (state == S_IDLE);
  assign accept    = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= 2'd1;
      width  <= 11'd640;
      height <= 16'd480;
      chans  <= 3'd3;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        imf_pkg::REG_RADIUS:   radius <= cfg_data[1:0];
        imf_pkg::REG_WIDTH:    width  <= cfg_data[10:0];
        imf_pkg::REG_HEIGHT:   height <= cfg_data[15:0];
        imf_pkg::REG_CHANNELS: chans  <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign n     = {radius, 1'b1};
  assign two_r = {radius, 1'b0};
  assign bad = (radius == 2'd0) || (int'(radius) > MAX_RADIUS) ||
               (int'(width) > MAX_WIDTH) || (chans == 3'd0) ||
               (int'(chans) > MAX_CHANNELS) ||
               (11'(n) > width) || (16'(n) > height);

  // frame start or a position left outside a changed image restarts the frame
  assign clr = s_tuser[0] || (int'(col) >= int'(width)) || (row >= height) ||
               (int'(ch) >= int'(chans));
  assign pc  = clr ? '0 : col;
  assign pr  = clr ? '0 : row;
  assign pch = clr ? '0 : ch;

  always_comb begin
    cur_slot = '0;
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      if (int'(radius) == k) begin
        cur_slot = clr ? '0 : slot_mod[k];
      end
    end
  end
  // oldest window row sits one slot after the current row
  assign first_slot = (int'(cur_slot) + 1 == int'(n)) ? '0 : cur_slot + SW'(1);

  assign has_win = (pr >= 16'(two_r)) && (int'(pc) >= int'(two_r));
  assign rend = (int'(pc) + 1 == int'(width)) && (int'(pch) + 1 == int'(chans));
  assign fend = rend && (int'(pr) + 1 == int'(height));

  always_comb begin
    col_next = pc;
    row_next = pr;
    ch_next  = pch;
    for (int k = 1; k <= MAX_RADIUS; k++) begin
      slot_next[k] = clr ? '0 : slot_mod[k];
    end
    if (int'(pch) + 1 >= int'(chans)) begin
      ch_next = '0;
      if (int'(pc) + 1 >= int'(width)) begin
        col_next = '0;
        if (int'(pr) + 1 >= int'(height)) begin
          row_next = '0;
          for (int k = 1; k <= MAX_RADIUS; k++) begin
            slot_next[k] = '0;
          end
        end else begin
          row_next = pr + 16'd1;
          for (int k = 1; k <= MAX_RADIUS; k++) begin
            slot_next[k] = (int'(slot_next[k]) == 2 * k) ? '0 : slot_next[k] + SW'(1);
          end
        end
      end else begin
        col_next = pc + CW'(1);
      end
    end else begin
      ch_next = pch + CHW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      ch  <= '0;
      for (int k = 1; k <= MAX_RADIUS; k++) begin
        slot_mod[k] <= '0;
      end
    end else if (accept) begin
      if (bad) begin
        if (s_tuser[0]) begin
          col <= '0;
          row <= '0;
          ch  <= '0;
          for (int k = 1; k <= MAX_RADIUS; k++) begin
            slot_mod[k] <= '0;
          end
        end
      end else begin
        col <= col_next;
        row <= row_next;
        ch  <= ch_next;
        for (int k = 1; k <= MAX_RADIUS; k++) begin
          slot_mod[k] <= slot_next[k];
        end
      end
    end
  end

  assign rd_issue = (state == S_READ);
  assign rd_last  = (int'(dr) + 1 == int'(n)) && (int'(dc) + 1 == int'(n));
  assign raddr    = {rd_slot, col_base + CW'(dc), wch};

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= rd_issue;
      unique case (state)
        S_IDLE: begin
          if (accept && (bad || has_win)) begin
            state <= bad ? S_DONE : S_READ;
          end
        end
        S_READ: begin
          if (rd_last) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: state <= S_DONE;
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_err  <= bad;
      res_rend <= rend;
      res_fend <= fend;
      rd_slot  <= first_slot;
      col_base <= pc - CW'(two_r);
      wch      <= pch;
      dr       <= '0;
      dc       <= '0;
    end else if (rd_issue) begin
      if (int'(dc) + 1 == int'(n)) begin
        dc      <= '0;
        dr      <= dr + SW'(1);
        rd_slot <= (int'(rd_slot) + 1 == int'(n)) ? '0 : rd_slot + SW'(1);
      end else begin
        dc <= dc + SW'(1);
      end
    end
  end

  imf_line_mem #(.AW(AW)) u_mem (
    .clk   (clk),
    .we    (accept && !bad),
    .waddr ({cur_slot, pc, pch}),
    .wdata (s_tdata),
    .re    (rd_issue),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign sctl.clear  = accept;
  assign sctl.insert = rd_pend;

  imf_sorter #(.MAX_RADIUS(MAX_RADIUS)) u_sort (
    .clk    (clk),
    .rst    (rst),
    .ctl    (sctl),
    .value  (rdata),
    .radius (radius),
    .median (median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && (!m_tvalid || m_tready)) begin
      m_tdata <= res_err ? 8'd0 : median;
      m_tlast <= !res_err && res_rend;
      m_tuser <= {res_err, !res_err && res_fend};
    end
  end
endmodule
`default_nettype wire

[rtl/imf_checker.sv]
// Port-level checks of the median filter output stream, bound to the top.
// Depends on image_median_filter_top_defines.svh and image_median_filter_top.
`default_nettype none
`include "image_median_filter_top_defines.svh"
module imf_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       m_tvalid,
  input wire logic       m_tready,
  input wire logic [7:0] m_tdata,
  input wire logic       m_tlast,
  input wire logic [1:0] m_tuser
);
  `MF_ASSERT_IMPLY(err_clean, clk, rst, m_tvalid && m_tuser[1], m_tdata == 8'd0 && !m_tlast && !m_tuser[0])
  `MF_ASSERT_IMPLY(frame_ends_row, clk, rst, m_tvalid && m_tuser[0], m_tlast)
  `MF_ASSERT_NEXT(hold_valid, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `MF_ASSERT_NEXT(hold_data, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
endmodule

bind image_median_filter_top imf_checker u_imf_checker (.*);
`default_nettype wire

[sim/image_median_filter_top_tb.sv]
// Self-checking bench for the streaming median filter: predicts each median
// from its own line store copy and checks the result stream. Needs imf_pkg.
`default_nettype none
module image_median_filter_top_tb;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = 60;

  // content styles of generated frames
  localparam int MODE_RANDOM  = 0;
  localparam int MODE_EXTREME = 1;
  localparam int MODE_LEVELS  = 2;

  typedef struct packed {
    logic [7:0] median;
    logic       row_end;
    logic       frame_end;
    logic       cfg_err;
  } median_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic [0:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [7:0] m_tdata;
  logic m_tlast;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [15:0] cfg_data = '0;

  always #5 clk = ~clk;

  image_median_filter_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predictor state
  logic [7:0]  pix_store [0:5*1024*4-1];
  int unsigned radius_q, width_q, height_q, chans_q;
  int unsigned col_q, row_q, chan_q;
  median_res_t medians_due[$];
  int errors = 0;
  int stall_pct;
  int idle_cycles = 0;
  bit timed_out = 1'b0;

  function automatic bit cfg_unusable();
    int unsigned n;
    n = 2 * radius_q + 1;
    if (radius_q == 0 || radius_q > 2) return 1'b1;
    if (width_q > 1024 || chans_q == 0 || chans_q > 4) return 1'b1;
    return (n > width_q) || (n > height_q);
  endfunction

  function automatic int unsigned pix_addr(int unsigned slot, int unsigned c,
                                           int unsigned ch);
    return (slot * 1024 + c) * 4 + ch;
  endfunction

  task automatic predict_median(input logic [7:0] smp, input logic fstart);
    logic [7:0] win [25];
    logic [7:0] v;
    int unsigned n, k, slot, rr, cc, ch;
    int j;
    median_res_t res;
    if (fstart) begin
      col_q = 0; row_q = 0; chan_q = 0;
    end
    if (cfg_unusable()) begin
      res = '{median: 8'd0, row_end: 1'b0, frame_end: 1'b0, cfg_err: 1'b1};
      medians_due = {medians_due, res};
      return;
    end
    if (col_q >= width_q || row_q >= height_q || chan_q >= chans_q) begin
      col_q = 0; row_q = 0; chan_q = 0;
    end
    n = 2 * radius_q + 1;
    rr = row_q; cc = col_q; ch = chan_q;
    pix_store[pix_addr(rr % n, cc, ch)] = smp;
    if (rr >= 2 * radius_q && cc >= 2 * radius_q) begin
      k = 0;
      for (int dr = 0; dr < n; dr++) begin
        slot = (rr - 2 * radius_q + dr) % n;
        for (int dc = 0; dc < n; dc++) begin
          win[k] = pix_store[pix_addr(slot, cc - 2 * radius_q + dc, ch)];
          k++;
        end
      end
      for (int i = 1; i < k; i++) begin
        v = win[i];
        j = i;
        while (j > 0 && win[j-1] > v) begin
          win[j] = win[j-1];
          j--;
        end
        win[j] = v;
      end
      res.median = win[k/2];
      res.row_end = (cc == width_q - 1) && (ch == chans_q - 1);
      res.frame_end = res.row_end && (rr == height_q - 1);
      res.cfg_err = 1'b0;
      medians_due = {medians_due, res};
    end
    ch++;
    if (ch >= chans_q) begin
      ch = 0;
      cc++;
      if (cc >= width_q) begin
        cc = 0;
        rr++;
        if (rr >= height_q) rr = 0;
      end
    end
    chan_q = ch; col_q = cc; row_q = rr;
  endtask

  // one request, with a random gap ahead of it now and then
  task automatic send_sample(input logic [7:0] smp, input logic fstart);
    if ($urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= smp;
    s_tuser  <= fstart;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_median(smp, fstart);
  endtask

  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (medians_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // valid stays up between back-to-back writes; set_image drops it
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      imf_pkg::REG_RADIUS:   radius_q = val & 16'h3;
      imf_pkg::REG_WIDTH:    width_q  = val & 16'h7FF;
      imf_pkg::REG_HEIGHT:   height_q = val;
      imf_pkg::REG_CHANNELS: chans_q  = val & 16'h7;
      default: ;
    endcase
  endtask

  task automatic set_image(input int r, input int w, input int h, input int c);
    wait_idle();
    write_reg(imf_pkg::REG_RADIUS, 16'(r));
    write_reg(imf_pkg::REG_WIDTH, 16'(w));
    write_reg(imf_pkg::REG_HEIGHT, 16'(h));
    write_reg(imf_pkg::REG_CHANNELS, 16'(c));
    cfg_valid <= 1'b0;
  endtask

  // whole frames with generated content
  task automatic send_frames(input int frames, input int mode, input bit mark_start);
    logic [7:0] v;
    for (int f = 0; f < frames; f++)
      for (int i = 0; i < width_q * height_q * chans_q; i++) begin
        case (mode)
          MODE_EXTREME: v = $urandom_range(0, 1) ? 8'hFF : 8'h00;
          MODE_LEVELS:  v = 8'($urandom_range(0, 3) * 8'h55);
          default: v = 8'($urandom);
        endcase
        send_sample(v, mark_start && i == 0);
      end
  endtask

  task automatic test_directed();
    set_image(1, 3, 3, 1);
    send_frames(1, MODE_EXTREME, 1'b1);
    set_image(2, 5, 5, 1);
    send_sample(8'h00, 1'b1);
    for (int i = 1; i < 24; i++) send_sample(i[0] ? 8'hFF : 8'h00, 1'b0);
    send_sample(8'h80, 1'b0);
  endtask

  task automatic test_config_errors();
    set_image(0, 8, 8, 1);
    send_sample(8'hAA, 1'b1);
    send_sample(8'h55, 1'b0);
    set_image(2, 4, 8, 1);
    send_sample(8'h12, 1'b0);
    set_image(1, 8, 2, 1);
    send_sample(8'h34, 1'b1);
    set_image(3, 8, 8, 1);
    send_sample(8'h56, 1'b0);
    set_image(1, 1025, 8, 1);
    send_sample(8'h78, 1'b0);
    set_image(1, 8, 8, 0);
    send_sample(8'h9A, 1'b0);
    set_image(1, 8, 8, 5);
    send_sample(8'hBC, 1'b0);
  endtask

  task automatic test_multichannel();
    set_image(1, 4, 4, 4);
    send_frames(2, MODE_RANDOM, 1'b1);
    set_image(1, 5, 3, 3);
    send_frames(2, MODE_LEVELS, 1'b0);
  endtask

  task automatic test_frame_restart();
    set_image(1, 6, 5, 2);
    for (int i = 0; i < 25; i++) send_sample(8'($urandom), i == 0);
    send_frames(1, MODE_RANDOM, 1'b1);
  endtask

  task automatic test_random_frames();
    int sent, r, w, h, c;
    sent = 0;
    while (sent < 250) begin
      r = $urandom_range(1, 2);
      w = $urandom_range(2 * r + 1, 9);
      h = $urandom_range(2 * r + 1, 6);
      c = $urandom_range(1, 4);
      stall_pct = $urandom_range(0, 2) * 30;
      set_image(r, w, h, c);
      send_frames(1, $urandom_range(0, 2), 1'($urandom_range(0, 1)));
      sent += w * h * c;
    end
    stall_pct = 20;
    set_image(1, 64, 3, 1);
    send_frames(1, MODE_RANDOM, 1'b1);
    set_image(1, 3, 65535, 1);
    for (int i = 0; i < 40; i++) send_sample(8'($urandom), i == 0);
  endtask

  // receiver stall pattern
  always @(posedge clk) begin
    if (rst) m_tready <= 1'b0;
    else m_tready <= ($urandom_range(0, 99) >= stall_pct);
  end

  always @(posedge clk) begin
    median_res_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (medians_due.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", m_tdata);
      end else begin
        want = medians_due.pop_front();
        if (want != {m_tdata, m_tlast, m_tuser[0], m_tuser[1]}) begin
          errors++;
          if (errors <= 10)
            $display("mismatch: exp med %h re %b fe %b err %b, got %h %b %b %b",
                     want.median, want.row_end, want.frame_end, want.cfg_err,
                     m_tdata, m_tlast, m_tuser[0], m_tuser[1]);
        end
      end
    end
  end

  // watchdog on cycles with no request moved
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
        (cfg_valid && cfg_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT && !timed_out) begin
      timed_out = 1'b1;
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    stall_pct = 25;
    radius_q = 1; width_q = 640; height_q = 480; chans_q = 3;
    col_q = 0; row_q = 0; chan_q = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_config_errors();
    test_multichannel();
    test_frame_restart();
    test_random_frames();
    wait_idle();
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
`default_nettype wire

[sim.f]
+incdir+rtl
rtl/imf_pkg.sv
rtl/imf_line_mem.sv
rtl/imf_sorter.sv
rtl/image_median_filter_top.sv
rtl/imf_checker.sv
sim/image_median_filter_top_tb.sv
